// ===== design/assert_macros.svh =====
// assertion macros used by the top-k score selector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define TKS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/tksel_pkg.sv =====
// types and constants of the top-k score selector
package tksel_pkg;

  localparam int unsigned ScoreW = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned RankW  = 4;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              last;
  } in_t;

  typedef struct packed {
    logic [RankW-1:0]  rank;
    logic [IdxW-1:0]   entry_index;
    logic [ScoreW-1:0] entry_score;
    logic              final_res;
  } out_t;

  // ranked entry held by one cell
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [IdxW-1:0]   idx;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

endpackage

// ===== design/top_k_score_selector.sv =====
// top-k score selector: sorted insertion chain with ranked read-out
//
// input channel (in_valid_i / in_stall_o / in_data_i): one score per request,
// last marks the end of a batch. while loading, a request is taken every
// cycle; each score is inserted into a chain of TOP_K cells kept in
// descending order (older entry first on equal scores). scores past
// MAX_ENTRIES in one batch are dropped, but their last flag still counts.
// after the last request the chain is read out from its head, one result per
// cycle while out_stall_i does not hold the output register: the state
// register moves to read-out, then the output register takes the first
// result. a batch of n entries yields min(n, TOP_K) results, the final one
// flagged. in_stall_o stays high during read-out, so the next request is
// taken only once the read-out is through; the output register sets the
// read-out pace. a stall on out_stall_i holds the result in the output
// register and pauses the read-out. reset empties the chain and the entry
// count and returns the block to loading.
module top_k_score_selector #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned TOP_K       = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tksel_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tksel_pkg::out_t out_data_o
);

  `include "assert_macros.svh"

  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RankCW = $clog2(TOP_K + 1);

  tksel_pkg::state_e state_d, state_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic [RankCW-1:0] rank_d, rank_q;
  logic              out_valid_d, out_valid_q;
  tksel_pkg::out_t   out_d, out_q;

  logic              in_acc, ins, pop, pop_final;
  tksel_pkg::cell_ctrl_t ctrl;
  tksel_pkg::entry_t new_entry;

  logic              valid_w [TOP_K+1];
  tksel_pkg::entry_t entry_w [TOP_K+1];
  logic              beats_w [TOP_K];
  logic [TOP_K-1:0]  valid_vec;

  assign in_acc    = in_valid_i && (state_q == tksel_pkg::ST_LOAD);
  assign ins       = in_acc && (cnt_q < CntW'(MAX_ENTRIES));
  assign pop       = (state_q == tksel_pkg::ST_DRAIN) && valid_w[0]
                     && (!out_valid_q || !out_stall_i);
  assign pop_final = !valid_w[1];

  assign new_entry.score = in_data_i.score;
  assign new_entry.idx   = tksel_pkg::IdxW'(cnt_q);
  assign ctrl.ins        = ins;
  assign ctrl.shift      = pop;

  // chain tail reads as empty
  assign valid_w[TOP_K] = 1'b0;
  assign entry_w[TOP_K] = '0;

  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    tksel_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (new_entry),
      .prev_valid_i ((i == 0) ? 1'b1 : valid_w[(i == 0) ? 0 : i-1]),
      .prev_i       ((i == 0) ? new_entry : entry_w[(i == 0) ? 0 : i-1]),
      .beats_prev_i ((i == 0) ? 1'b0 : beats_w[(i == 0) ? 0 : i-1]),
      .next_valid_i (valid_w[i+1]),
      .next_i       (entry_w[i+1]),
      .beats_o      (beats_w[i]),
      .valid_o      (valid_w[i]),
      .entry_o      (entry_w[i])
    );
    assign valid_vec[i] = valid_w[i];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tksel_pkg::ST_LOAD: begin
        if (in_acc && in_data_i.last) begin
          state_d = tksel_pkg::ST_DRAIN;
        end
      end
      tksel_pkg::ST_DRAIN: begin
        if (pop && pop_final) begin
          state_d = tksel_pkg::ST_LOAD;
        end
      end
      default: state_d = tksel_pkg::ST_LOAD;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    case (state_q)
      tksel_pkg::ST_LOAD:  in_stall_o = 1'b0;
      tksel_pkg::ST_DRAIN: in_stall_o = 1'b1;
      default:             in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    rank_d = rank_q;
    if (in_acc && in_data_i.last) begin
      cnt_d  = '0;
      rank_d = RankCW'(1);
    end else if (ins) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (pop) begin
      rank_d = rank_q + RankCW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop) begin
      out_valid_d       = 1'b1;
      out_d.rank        = tksel_pkg::RankW'(rank_q);
      out_d.entry_index = entry_w[0].idx;
      out_d.entry_score = entry_w[0].score;
      out_d.final_res   = pop_final;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tksel_pkg::ST_LOAD;
      cnt_q       <= '0;
      rank_q      <= RankCW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rank_q      <= rank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // occupied cells always form a run from the head
  `TKS_ASSERT(a_cells_packed, (valid_vec & (valid_vec + 1'b1)) == '0, "chain has a hole")
  `TKS_ASSERT(a_last_starts_drain,
              in_acc && in_data_i.last |=> (state_q == tksel_pkg::ST_DRAIN) && valid_w[0],
              "last request did not start read-out with a filled head")
  `TKS_ASSERT(a_final_ends_drain,
              pop && pop_final |=> (state_q == tksel_pkg::ST_LOAD) && valid_vec == '0
                                   && out_data_o.final_res,
              "final result did not empty the chain")
  `TKS_ASSERT_NEVER(a_count_range, cnt_q > CntW'(MAX_ENTRIES), "entry count beyond store size")

endmodule

// ===== design/tksel_cell.sv =====
// one cell of the sorted insertion chain
module tksel_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tksel_pkg::cell_ctrl_t ctrl_i,
  input  tksel_pkg::entry_t   new_i,
  input  logic                prev_valid_i,
  input  tksel_pkg::entry_t   prev_i,
  input  logic                beats_prev_i,
  input  logic                next_valid_i,
  input  tksel_pkg::entry_t   next_i,
  output logic                beats_o,
  output logic                valid_o,
  output tksel_pkg::entry_t   entry_o
);

  logic              valid_d, valid_q;
  tksel_pkg::entry_t entry_d, entry_q;

  // strict compare keeps the older entry ahead on equal scores
  assign beats_o = !valid_q || (new_i.score > entry_q.score);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      entry_d = next_i;
    end else if (ctrl_i.ins) begin
      if (beats_prev_i) begin
        valid_d = prev_valid_i;
        entry_d = prev_i;
      end else if (beats_o) begin
        valid_d = 1'b1;
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule
